// ===== src/htwd_pkg.sv =====
`timescale 1ns / 1ps
// htwd_pkg: shared constants and types for the huffman tree walk decoder
// no dependencies; used by htwd_ram users and the top level

package htwd_pkg;

   // node table geometry
   localparam int NODE_COUNT    = 256;
   localparam int NODE_AW       = $clog2(NODE_COUNT);
   localparam int NODE_W        = 25;

   // code bits consumed per decode request
   localparam int BITS_PER_ITEM = 8;
   localparam int BIT_CNT_W     = $clog2(BITS_PER_ITEM + 1);

   // request kind codes
   localparam logic KIND_LOAD   = 1'b0;
   localparam logic KIND_DECODE = 1'b1;

   // one stored tree node
   typedef struct packed {
      logic       leaf;
      logic [7:0] left;
      logic [7:0] right;
      logic [7:0] symbol;
   } node_type;

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_FLUSH
   } st_type;

endpackage

// ===== src/htwd_ram.sv =====
`timescale 1ns / 1ps
// htwd_ram: generic single write port, single read port ram with registered read
// no dependencies

module htwd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read, held while not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/huffman_tree_walk_decoder_top.sv =====
`timescale 1ns / 1ps
// huffman tree walk decoder: a load request writes one node; a decode request walks one
// code bit per cycle unless a found symbol waits on a stalled result side, reading the
// chosen child per bit unless on a leaf, then resolves the last read and flushes the held
// symbol. The node read chain (read child, test leaf, pick next child) sets the one bit
// per cycle. Synchronous active high reset puts the walk position at the root and empties
// the result path; the node table is not cleared. Depends on htwd_pkg and htwd_ram.

module huffman_tree_walk_decoder_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_kind,
   input  logic [7:0] req_node_addr,
   input  logic       req_node_is_leaf,
   input  logic [7:0] req_left_child,
   input  logic [7:0] req_right_child,
   input  logic [7:0] req_node_symbol,
   input  logic [7:0] req_code_byte,
   input  logic       req_end_of_message,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_symbol,
   output logic       rsp_last
);

   htwd_pkg::st_type   state_ff, state_in;
   logic [7:0]         pos_ff, pos_in;
   htwd_pkg::node_type cur_ff, cur_in;
   htwd_pkg::node_type root_ff, root_in;
   logic               pend_ff, pend_in;
   logic [7:0]         pend_addr_ff, pend_addr_in;
   logic [htwd_pkg::BITS_PER_ITEM-1:0] code_ff, code_in;
   logic               eom_ff, eom_in;
   logic [htwd_pkg::BIT_CNT_W-1:0] bits_left_ff, bits_left_in;
   logic               hold_vld_ff, hold_vld_in;
   logic [7:0]         hold_sym_ff, hold_sym_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [7:0]         rsp_symbol_ff, rsp_symbol_in;
   logic               rsp_last_ff, rsp_last_in;

   logic                          ram_wr_en;
   logic [htwd_pkg::NODE_AW-1:0]  ram_wr_addr;
   logic [htwd_pkg::NODE_W-1:0]   ram_wr_data;
   logic                          ram_rd_en;
   logic [htwd_pkg::NODE_AW-1:0]  ram_rd_addr;
   logic [htwd_pkg::NODE_W-1:0]   ram_rd_data;

   htwd_pkg::node_type fetched;
   htwd_pkg::node_type node_now;
   htwd_pkg::node_type load_node;
   logic [7:0]         pos_now;
   logic               emit_now;
   logic               out_free;
   logic               advance;
   logic               code_bit;
   logic [7:0]         child;

   // node table
   htwd_ram #(
      .WIDTH (htwd_pkg::NODE_W),
      .DEPTH (htwd_pkg::NODE_COUNT)
   ) u_node_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= htwd_pkg::ST_IDLE;
         pos_ff       <= '0;
         pend_ff      <= 1'b0;
         bits_left_ff <= '0;
         hold_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         pend_ff      <= pend_in;
         bits_left_ff <= bits_left_in;
         hold_vld_ff  <= hold_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cur_ff        <= cur_in;
      root_ff       <= root_in;
      pend_addr_ff  <= pend_addr_in;
      code_ff       <= code_in;
      eom_ff        <= eom_in;
      hold_sym_ff   <= hold_sym_in;
      rsp_symbol_ff <= rsp_symbol_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // node currently under the walk, after the read of the previous bit resolves
   always_comb begin
      fetched  = htwd_pkg::node_type'(ram_rd_data);
      node_now = cur_ff;
      pos_now  = pos_ff;
      emit_now = 1'b0;
      if (pend_ff) begin
         if (fetched.leaf) begin
            node_now = root_ff;
            pos_now  = '0;
            emit_now = 1'b1;
         end else begin
            node_now = fetched;
            pos_now  = pend_addr_ff;
         end
      end
   end

   // sequencer: next state and datapath controls
   always_comb begin
      state_in      = state_ff;
      pos_in        = pos_ff;
      cur_in        = cur_ff;
      root_in       = root_ff;
      pend_in       = pend_ff;
      pend_addr_in  = pend_addr_ff;
      code_in       = code_ff;
      eom_in        = eom_ff;
      bits_left_in  = bits_left_ff;
      hold_vld_in   = hold_vld_ff;
      hold_sym_in   = hold_sym_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_symbol_in = rsp_symbol_ff;
      rsp_last_in   = rsp_last_ff;

      load_node.leaf   = req_node_is_leaf;
      load_node.left   = req_left_child;
      load_node.right  = req_right_child;
      load_node.symbol = req_node_symbol;

      ram_wr_en   = 1'b0;
      ram_wr_addr = htwd_pkg::NODE_AW'(req_node_addr);
      ram_wr_data = load_node;
      ram_rd_en   = 1'b0;
      ram_rd_addr = '0;

      out_free = !rsp_valid_ff || !rsp_stall;
      advance  = !(emit_now && hold_vld_ff) || out_free;
      code_bit = code_ff[htwd_pkg::BITS_PER_ITEM-1];
      child    = code_bit ? node_now.right : node_now.left;

      unique case (state_ff)
         htwd_pkg::ST_IDLE: begin
            if (req_valid) begin
               if (req_kind == htwd_pkg::KIND_LOAD) begin
                  // node write, mirrored into the root or current node copy when its address matches
                  if (32'(req_node_addr) < htwd_pkg::NODE_COUNT) begin
                     ram_wr_en = 1'b1;
                     if (req_node_addr == pos_ff) begin
                        cur_in = load_node;
                     end
                     if (req_node_addr == '0) begin
                        root_in = load_node;
                     end
                  end
               end else begin
                  code_in      = htwd_pkg::BITS_PER_ITEM'(req_code_byte);
                  eom_in       = req_end_of_message;
                  bits_left_in = htwd_pkg::BIT_CNT_W'(htwd_pkg::BITS_PER_ITEM);
                  state_in     = htwd_pkg::ST_WALK;
               end
            end
         end

         htwd_pkg::ST_WALK: begin
            if (advance) begin
               pend_in = 1'b0;
               // leaf reached: older held symbol moves out, new one is held
               if (emit_now) begin
                  if (hold_vld_ff) begin
                     rsp_valid_in  = 1'b1;
                     rsp_symbol_in = hold_sym_ff;
                     rsp_last_in   = 1'b0;
                  end
                  hold_vld_in = 1'b1;
                  hold_sym_in = fetched.symbol;
               end
               if (bits_left_ff != '0) begin
                  // step one code bit
                  bits_left_in = bits_left_ff - 1'b1;
                  code_in      = code_ff << 1;
                  if (node_now.leaf) begin
                     cur_in = node_now;
                     pos_in = pos_now;
                  end else if (32'(child) < htwd_pkg::NODE_COUNT) begin
                     ram_rd_en    = 1'b1;
                     ram_rd_addr  = htwd_pkg::NODE_AW'(child);
                     pend_in      = 1'b1;
                     pend_addr_in = child;
                  end else begin
                     pos_in = '0;
                     cur_in = root_ff;
                  end
               end else begin
                  // all bits stepped, optional return to root
                  pos_in   = eom_ff ? 8'd0 : pos_now;
                  cur_in   = eom_ff ? root_ff : node_now;
                  state_in = htwd_pkg::ST_FLUSH;
               end
            end
         end

         htwd_pkg::ST_FLUSH: begin
            // held symbol is the final one of this request
            if (!hold_vld_ff) begin
               state_in = htwd_pkg::ST_IDLE;
            end else if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_symbol_in = hold_sym_ff;
               rsp_last_in   = 1'b1;
               hold_vld_in   = 1'b0;
               state_in      = htwd_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = htwd_pkg::ST_IDLE;
         end
      endcase
   end

   assign req_stall  = (state_ff != htwd_pkg::ST_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_symbol = rsp_symbol_ff;
   assign rsp_last   = rsp_last_ff;

   // a node read is only outstanding during the walk
   a_pend_in_walk: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> (state_ff == htwd_pkg::ST_WALK))
      else $error("node read outstanding outside walk");

   // no symbol is left behind when a request completes
   a_hold_empty_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == htwd_pkg::ST_IDLE) |-> !hold_vld_ff)
      else $error("held symbol while idle");

   // bit counter never exceeds one request's bits
   a_bits_bound: assert property (@(posedge clock) disable iff (reset)
      bits_left_ff <= htwd_pkg::BIT_CNT_W'(htwd_pkg::BITS_PER_ITEM))
      else $error("bit counter out of range");

   // a final-flagged result only appears from the flush step
   a_last_from_flush: assert property (@(posedge clock) disable iff (reset)
      ($rose(rsp_valid_ff) && rsp_last_ff) |-> ($past(state_ff) == htwd_pkg::ST_FLUSH))
      else $error("last result outside flush");

endmodule

// ===== dv/huffman_tree_walk_decoder_top_test.sv =====
`timescale 1ns / 1ps
// self-checking testbench for huffman_tree_walk_decoder_top: loads code trees, decodes
// random code bytes and checks every symbol against an in-bench tree walk
// depends on htwd_pkg and the decoder rtl

module huffman_tree_walk_decoder_top_test;

   localparam int MAX_SYMBOLS     = 8;
   localparam int TARGET_REQUESTS = 280;
   localparam int CYCLE_LIMIT     = 600000;

   // one request as seen on the input ports
   typedef struct packed {
      logic       kind;
      logic [7:0] node_addr;
      logic       node_is_leaf;
      logic [7:0] left_child;
      logic [7:0] right_child;
      logic [7:0] node_symbol;
      logic [7:0] code_byte;
      logic       end_of_message;
   } req_item_type;

   typedef struct packed {
      logic [7:0] symbol;
      logic       last;
   } sym_result_type;

   // tree walk predictor and the symbols it still waits for
   class symbol_scoreboard_type;
      htwd_pkg::node_type node_mem [htwd_pkg::NODE_COUNT];
      logic [7:0]         walk_node;
      sym_result_type     pending [$];
      int                 errors;

      function new();
         walk_node = '0;
         errors    = 0;
      endfunction

      function void note_request(req_item_type r);
         htwd_pkg::node_type here;
         logic [7:0]         nxt;
         logic               code_bit;
         logic [7:0]         found [MAX_SYMBOLS];
         int                 count;
         count = 0;
         if (r.kind == htwd_pkg::KIND_LOAD) begin
            // every field is stored whatever the node kind
            if (int'(r.node_addr) < htwd_pkg::NODE_COUNT)
               node_mem[r.node_addr] = '{leaf: r.node_is_leaf, left: r.left_child,
                                         right: r.right_child, symbol: r.node_symbol};
         end else begin
            // walk msb first, one step per code bit
            for (int b = htwd_pkg::BITS_PER_ITEM - 1; b >= 0; b--) begin
               code_bit = (b < 8) ? r.code_byte[b] : 1'b0;
               if (int'(walk_node) >= htwd_pkg::NODE_COUNT) walk_node = '0;
               here = node_mem[walk_node];
               // standing on a leaf: the bit is dropped
               if (!here.leaf) begin
                  nxt = code_bit ? here.right : here.left;
                  if (int'(nxt) >= htwd_pkg::NODE_COUNT) begin
                     walk_node = '0;
                  end else if (node_mem[nxt].leaf) begin
                     if (count < MAX_SYMBOLS) found[count] = node_mem[nxt].symbol;
                     count++;
                     walk_node = '0;
                  end else begin
                     walk_node = nxt;
                  end
               end
            end
            if (count > MAX_SYMBOLS) count = MAX_SYMBOLS;
            for (int i = 0; i < count; i++)
               pending.insert(pending.size(),
                              sym_result_type'{symbol: found[i], last: (i == count - 1)});
            if (r.end_of_message) walk_node = '0;
         end
      endfunction

      function void check_symbol(logic [7:0] sym, logic last);
         sym_result_type want;
         if (pending.size() == 0) begin
            $display("%0t: unexpected symbol: expected none, actual %02h last %0b",
                     $time, sym, last);
            errors++;
         end else begin
            want = pending.pop_front();
            if (sym !== want.symbol) begin
               $display("%0t: symbol mismatch: expected %02h, actual %02h",
                        $time, want.symbol, sym);
               errors++;
            end
            if (last !== want.last) begin
               $display("%0t: last mismatch on symbol %02h: expected %0b, actual %0b",
                        $time, want.symbol, want.last, last);
               errors++;
            end
         end
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic       req_kind = htwd_pkg::KIND_LOAD;
   logic [7:0] req_node_addr = '0;
   logic       req_node_is_leaf = 1'b0;
   logic [7:0] req_left_child = '0;
   logic [7:0] req_right_child = '0;
   logic [7:0] req_node_symbol = '0;
   logic [7:0] req_code_byte = '0;
   logic       req_end_of_message = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_symbol;
   logic       rsp_last;

   symbol_scoreboard_type sb = new();

   int cycle_count = 0;
   int stall_count = 0;
   bit rsp_calm = 1'b0;
   bit req_calm = 1'b0;
   int requests_sent = 0;

   // nodes written so far; branches only ever point at written nodes
   bit node_written [htwd_pkg::NODE_COUNT];
   int written_list [$];
   bit tree_taken [htwd_pkg::NODE_COUNT];

   huffman_tree_walk_decoder_top u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_kind           (req_kind),
      .req_node_addr      (req_node_addr),
      .req_node_is_leaf   (req_node_is_leaf),
      .req_left_child     (req_left_child),
      .req_right_child    (req_right_child),
      .req_node_symbol    (req_node_symbol),
      .req_code_byte      (req_code_byte),
      .req_end_of_message (req_end_of_message),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_symbol         (rsp_symbol),
      .rsp_last           (rsp_last)
   );

   // 2 ns clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("** huffman_tree_walk_decoder_top: FAILED **");
         $finish;
      end
   end

   // result side stalls: calm stretches, short bursts, a few long holds
   always @(posedge clock) begin
      if (cycle_count % 128 == 0) rsp_calm <= ($urandom_range(0, 3) == 0);
      if (stall_count != 0) begin
         stall_count <= stall_count - 1;
         rsp_stall   <= 1'b1;
      end else if (!rsp_calm && $urandom_range(0, 99) < 25) begin
         rsp_stall   <= 1'b1;
         stall_count <= ($urandom_range(0, 9) == 0) ? int'($urandom_range(5, 30))
                                                    : int'($urandom_range(0, 2));
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // sample both handshakes at the edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            sb.note_request(req_item_type'{req_kind, req_node_addr, req_node_is_leaf,
                                           req_left_child, req_right_child,
                                           req_node_symbol, req_code_byte,
                                           req_end_of_message});
         if (rsp_valid && !rsp_stall) sb.check_symbol(rsp_symbol, rsp_last);
      end
   end

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (req_calm || roll < 55) pick_gap = 0;
      else if (roll < 90)        pick_gap = $urandom_range(1, 3);
      else                       pick_gap = $urandom_range(6, 40);
   endfunction

   function automatic int fresh_addr();
      int a;
      a = $urandom_range(1, htwd_pkg::NODE_COUNT - 1);
      while (tree_taken[a]) a = $urandom_range(1, htwd_pkg::NODE_COUNT - 1);
      tree_taken[a] = 1'b1;
      fresh_addr = a;
   endfunction

   // present one request and hold it until accepted
   task automatic send_request(input req_item_type r);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_kind           <= r.kind;
      req_node_addr      <= r.node_addr;
      req_node_is_leaf   <= r.node_is_leaf;
      req_left_child     <= r.left_child;
      req_right_child    <= r.right_child;
      req_node_symbol    <= r.node_symbol;
      req_code_byte      <= r.code_byte;
      req_end_of_message <= r.end_of_message;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      requests_sent++;
   endtask

   task automatic send_load(input logic [7:0] addr, input logic leaf, input logic [7:0] left,
                            input logic [7:0] right, input logic [7:0] sym);
      send_request('{kind: htwd_pkg::KIND_LOAD, node_addr: addr, node_is_leaf: leaf,
                     left_child: left, right_child: right, node_symbol: sym,
                     code_byte: 8'($urandom_range(0, 255)),
                     end_of_message: 1'($urandom_range(0, 1))});
      if (!node_written[addr]) begin
         node_written[addr] = 1'b1;
         written_list.insert(written_list.size(), int'(addr));
      end
   endtask

   task automatic send_decode(input logic [7:0] code, input logic eom);
      send_request('{kind: htwd_pkg::KIND_DECODE, node_addr: 8'($urandom_range(0, 255)),
                     node_is_leaf: 1'($urandom_range(0, 1)),
                     left_child: 8'($urandom_range(0, 255)),
                     right_child: 8'($urandom_range(0, 255)),
                     node_symbol: 8'($urandom_range(0, 255)),
                     code_byte: code, end_of_message: eom});
   endtask

   // random rewrite of any node, branches only to written nodes
   task automatic noise_load();
      logic leaf;
      leaf = 1'($urandom_range(0, 1));
      if (leaf)
         send_load(8'($urandom_range(0, 255)), 1'b1, 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      else
         send_load(8'($urandom_range(0, 255)), 1'b0,
                   8'(written_list[$urandom_range(0, written_list.size() - 1)]),
                   8'(written_list[$urandom_range(0, written_list.size() - 1)]),
                   8'($urandom_range(0, 255)));
   endtask

   // full binary tree rooted at node 0; chain shape gives codes longer than a byte
   task automatic load_random_tree(input int leaves, input bit chain);
      int pool [$];
      int a, b, pick, parent;
      for (int i = 0; i < htwd_pkg::NODE_COUNT; i++) tree_taken[i] = 1'b0;
      tree_taken[0] = 1'b1;
      if (leaves == 1) begin
         send_load(8'd0, 1'b1, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)));
      end else begin
         repeat (leaves) begin
            parent = fresh_addr();
            send_load(8'(parent), 1'b1, 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            pool.insert(pool.size(), parent);
         end
         while (pool.size() > 1) begin
            if (chain) begin
               a = pool.pop_back();
               b = pool.pop_front();
            end else begin
               pick = $urandom_range(0, pool.size() - 1);
               a    = pool[pick];
               pool.delete(pick);
               pick = $urandom_range(0, pool.size() - 1);
               b    = pool[pick];
               pool.delete(pick);
            end
            if ($urandom_range(0, 1) == 1) begin
               pick = a;
               a    = b;
               b    = pick;
            end
            parent = (pool.size() == 0) ? 0 : fresh_addr();
            send_load(8'(parent), 1'b0, 8'(a), 8'(b), 8'($urandom_range(0, 255)));
            pool.insert(pool.size(), parent);
         end
      end
   endtask

   // hand-picked trees and codes
   task automatic run_directed();
      // leaf at the root swallows all bits
      send_load(8'd0, 1'b1, 8'hFF, 8'h00, 8'hFF);
      send_decode(8'hFF, 1'b0);
      send_decode(8'h00, 1'b1);
      // small tree: 0 -> 1 leaf | 2 ; 2 -> 3 leaf | 255 leaf
      send_load(8'd1, 1'b1, 8'h00, 8'hFF, 8'h00);
      send_load(8'd255, 1'b1, 8'hFF, 8'hFF, 8'hFF);
      send_load(8'd3, 1'b1, 8'h55, 8'hAA, 8'hA5);
      send_load(8'd2, 1'b0, 8'd3, 8'd255, 8'h00);
      send_load(8'd0, 1'b0, 8'd1, 8'd2, 8'h5A);
      // eight symbols from one byte, then mixed codes
      send_decode(8'h00, 1'b0);
      send_decode(8'hFF, 1'b0);
      send_decode(8'hAA, 1'b0);
      // end of message drops a half-walked code
      send_decode(8'h01, 1'b1);
      send_decode(8'h80, 1'b0);
      // node under the walk becomes a leaf, only end of message gets out
      send_decode(8'h01, 1'b0);
      send_load(8'd2, 1'b1, 8'd3, 8'd255, 8'h3C);
      send_decode(8'hFF, 1'b0);
      send_decode(8'h00, 1'b1);
      send_load(8'd2, 1'b0, 8'd3, 8'd255, 8'h00);
      send_decode(8'h7F, 1'b0);
      // root pointing to itself: zero bits loop without output
      send_load(8'd0, 1'b0, 8'd0, 8'd2, 8'h00);
      send_decode(8'h00, 1'b0);
      send_decode(8'h01, 1'b0);
      send_load(8'd0, 1'b0, 8'd1, 8'd2, 8'h5A);
   endtask

   task automatic run_random_phase();
      int leaves, decodes;
      req_calm = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 19) == 0)     leaves = 1;
      else if ($urandom_range(0, 4) == 0) leaves = $urandom_range(9, 20);
      else                                leaves = $urandom_range(2, 8);
      load_random_tree(leaves, $urandom_range(0, 3) == 0);
      decodes = $urandom_range(6, 24);
      repeat (decodes) begin
         if ($urandom_range(0, 9) == 0) noise_load();
         send_decode(8'($urandom_range(0, 255)), $urandom_range(0, 6) == 0);
      end
   endtask

   // main sequence
   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      run_directed();
      while (requests_sent < TARGET_REQUESTS) run_random_phase();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("** huffman_tree_walk_decoder_top: PASSED **");
      end else begin
         $display("** huffman_tree_walk_decoder_top: FAILED **");
      end
      $finish;
   end

endmodule
